// ===== rtl/core/dkas_pkg.sv =====
// Package for the dual knob sampler: phase codes, register indexes and shared types.
`timescale 1ns / 1ps

package dkas_pkg;

    // Sampling pattern
    localparam int unsigned SAMPLES_PER_KNOB = 8;
    localparam int unsigned AVG_SHIFT        = $clog2(SAMPLES_PER_KNOB);
    localparam logic [7:0]  FULL_SCALE       = 8'hFF;

    // Field widths
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned ACC_W    = 11;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WAIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_WAIT = 2'd2;

    // Sequencer phase; the fourth code acts as idle
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_KNOB0 = 2'd1,
        PH_KNOB1 = 2'd2
    } dkas_phase_t;

    typedef struct packed {
        logic [7:0]        threshold;
        logic [TIME_W-1:0] short_wait;
        logic [TIME_W-1:0] settle_wait;
    } dkas_cfg_t;

    typedef struct packed {
        dkas_phase_t        phase;
        logic [TIME_W-1:0]  start_time;
        logic [COUNT_W-1:0] sample_count;
        logic [ACC_W-1:0]   accumulator;
        logic [7:0]         raw_kept0;
        logic [7:0]         raw_kept1;
        logic [7:0]         knob0_now;
        logic [7:0]         knob0_before;
        logic [7:0]         knob1_now;
        logic [7:0]         knob1_before;
        logic               switch_state;
    } dkas_state_t;

endpackage

// ===== rtl/core/dkas_if.sv =====
// Channel interfaces of the dual knob sampler: poll requests, results, register writes.
`timescale 1ns / 1ps

interface dkas_item_if;
    logic                           valid;
    logic                           ready;
    logic [dkas_pkg::TIME_W-1:0]    now;
    logic [dkas_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output now, output sample, input ready);
    modport sink   (input valid, input now, input sample, output ready);
endinterface

interface dkas_result_if;
    logic       valid;
    logic       ready;
    logic       stepped;
    logic [7:0] knob0_now;
    logic [7:0] knob0_before;
    logic [7:0] knob1_now;
    logic [7:0] knob1_before;
    logic       mux_select;

    modport source (output valid, output stepped, output knob0_now, output knob0_before,
                    output knob1_now, output knob1_before, output mux_select,
                    input ready);
    modport sink   (input valid, input stepped, input knob0_now, input knob0_before,
                    input knob1_now, input knob1_before, input mux_select,
                    output ready);
endinterface

interface dkas_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dkas_pkg::CFG_IDX_W-1:0]    index;
    logic [dkas_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/dual_knob_adc_sampler_unit.sv =====
// Top level of the dual knob converter sampler.
`timescale 1ns / 1ps

// Takes one poll request per cycle as long as results are taken. A request is held in an
// input register, its state update is worked out there, and the result lands in an
// output register, which drives the result channel. While a
// result waits to be taken, one more request can enter the input register; after that
// the input stalls until the result is taken. The sequencer state (phase, timestamp,
// accumulator, kept values) advances as each request leaves the input register.
// Registers are written through the config channel, always ready, and should only be
// changed while no request is in flight.
module dual_knob_adc_sampler_unit (
    input  logic          clk,
    input  logic          rst_n,
    dkas_item_if.sink     item,
    dkas_result_if.source result,
    dkas_cfg_if.sink      cfg
);
    import dkas_pkg::*;

    dkas_cfg_t             cfg_reg;
    dkas_state_t           state_reg;
    dkas_state_t           state_next;
    logic [TIME_W-1:0]     now_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  stepped;
    logic                  advance;
    logic                  stepped_reg;

    // Handshake control
    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item.ready)
            s1_valid_next = item.valid;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            now_reg    <= item.now;
            sample_reg <= item.sample;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_THRESHOLD:   cfg_reg.threshold   <= cfg.data[7:0];
                CFG_SHORT_WAIT:  cfg_reg.short_wait  <= cfg.data[TIME_W-1:0];
                CFG_SETTLE_WAIT: cfg_reg.settle_wait <= cfg.data[TIME_W-1:0];
                default:         ;
            endcase
        end
    end

    // Poll evaluation
    dkas_step u_step (
        .st      (state_reg),
        .cfg     (cfg_reg),
        .now     (now_reg),
        .sample  (sample_reg),
        .st_next (state_next),
        .stepped (stepped)
    );

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '{phase: PH_IDLE, default: '0};
        else if (advance)
            state_reg <= state_next;
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance)
            stepped_reg <= stepped;
    end

    assign result.valid        = out_valid_reg;
    assign result.stepped      = stepped_reg;
    assign result.knob0_now    = state_reg.knob0_now;
    assign result.knob0_before = state_reg.knob0_before;
    assign result.knob1_now    = state_reg.knob1_now;
    assign result.knob1_before = state_reg.knob1_before;
    assign result.mux_select   = state_reg.switch_state;

endmodule

// ===== rtl/core/dkas_step.sv =====
// Next-state logic for one poll: wait test, accumulate, average, hysteresis, quantize.
`timescale 1ns / 1ps

module dkas_step (
    input  dkas_pkg::dkas_state_t            st,
    input  dkas_pkg::dkas_cfg_t              cfg,
    input  logic [dkas_pkg::TIME_W-1:0]      now,
    input  logic [dkas_pkg::SAMPLE_W-1:0]    sample,
    output dkas_pkg::dkas_state_t            st_next,
    output logic                             stepped
);
    import dkas_pkg::*;

    logic                knob;
    logic [TIME_W-1:0]   wait_sel;
    logic [TIME_W-1:0]   deadline;
    logic [TIME_W-1:0]   elapsed;
    logic [ACC_W-1:0]    acc_sum;
    logic [COUNT_W-1:0]  count_inc;
    logic [7:0]          avg;
    logic [7:0]          kept;
    logic [7:0]          delta;
    logic                take;
    logic [7:0]          chosen;
    logic [7:0]          quant;

    // Wait test: signed difference to deadline must be positive
    assign knob     = (st.phase == PH_KNOB0) || (st.phase == PH_KNOB1);
    assign wait_sel = (knob && (st.sample_count == '0)) ? cfg.settle_wait : cfg.short_wait;
    assign deadline = st.start_time + wait_sel;
    assign elapsed  = now - deadline;
    assign stepped  = (elapsed != '0) && !elapsed[TIME_W-1];

    // Accumulate and average
    assign acc_sum   = st.accumulator + ACC_W'(sample);
    assign count_inc = st.sample_count + COUNT_W'(1);
    assign avg       = acc_sum[AVG_SHIFT +: 8];

    // Hysteresis against the last accepted raw value, then quantize
    assign kept   = (st.phase == PH_KNOB0) ? st.raw_kept0 : st.raw_kept1;
    assign delta  = (avg > kept) ? (avg - kept) : (kept - avg);
    assign take   = delta > (cfg.threshold >> 2);
    assign chosen = take ? avg : kept;
    assign quant  = (chosen == FULL_SCALE) ? chosen : (chosen & ~cfg.threshold);

    // State update
    always_comb
    begin
        st_next = st;
        if (stepped)
        begin
            st_next.start_time = now;
            case (st.phase)
                PH_KNOB0, PH_KNOB1:
                begin
                    st_next.accumulator  = acc_sum;
                    st_next.sample_count = count_inc;
                    if (count_inc == COUNT_W'(SAMPLES_PER_KNOB))
                    begin
                        st_next.sample_count = '0;
                        st_next.accumulator  = '0;
                        if (st.phase == PH_KNOB0)
                        begin
                            if (take)
                                st_next.raw_kept0 = avg;
                            st_next.knob0_before = st.knob0_now;
                            st_next.knob0_now    = quant;
                            st_next.phase        = PH_KNOB1;
                            st_next.switch_state = 1'b1;
                        end
                        else
                        begin
                            if (take)
                                st_next.raw_kept1 = avg;
                            st_next.knob1_before = st.knob1_now;
                            st_next.knob1_now    = quant;
                            st_next.phase        = PH_IDLE;
                            st_next.switch_state = 1'b0;
                        end
                    end
                end
                default:
                begin
                    st_next.switch_state = 1'b0;
                    st_next.phase        = PH_KNOB0;
                end
            endcase
        end
    end

endmodule
